[design/fbfla_pkg.sv]
// ----------------------------------------------------------------------------
// fbfla_pkg
// shared widths, codes and types of the fixed block free list allocator
// ----------------------------------------------------------------------------
package fbfla_pkg;

  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int SIZE_W     = 17;
  localparam int ADDR_W     = 27;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'd1;

  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 11'd1024;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 17'd64;

  typedef struct packed {
    logic             is_free;
    logic             range_bad;
    logic [IDX_W-1:0] idx;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  gidx;
    logic [ADDR_W-1:0] gaddr;
    logic [ADDR_W-1:0] used;
    logic [CNT_W-1:0]  live;
  } rsp_t;

endpackage

[design/fixed_block_free_list_allocator.sv]
// a taken request is written to the queue, then its result and strobe are registered
// throughput: one request per cycle; a pop forwards the link read from the
//   single-port link store straight into the next request, so busy stays low
// the result channel has no back pressure, out_valid lasts one cycle
// reset: synchronous, clears counters, free list head and queue; the link
//   store is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// fixed-size block pool allocator with a lifo free list and usage counters
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS   = 1024,
  parameter int HEADER_BYTES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_operation,
  input  logic [fbfla_pkg::IDX_W-1:0]        in_block_index,
  output logic                               out_valid,
  output logic [fbfla_pkg::ST_W-1:0]         out_status,
  output logic [fbfla_pkg::IDX_W-1:0]        out_granted_index,
  output logic [fbfla_pkg::ADDR_W-1:0]       out_granted_address,
  output logic [fbfla_pkg::ADDR_W-1:0]       out_bytes_in_use,
  output logic [fbfla_pkg::CNT_W-1:0]        out_live_allocations,
  input  logic                               cfg_wr_en,
  input  logic [fbfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbfla_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [fbfla_pkg::CNT_W-1:0]  block_count_r;
  logic [fbfla_pkg::CNT_W-1:0]  block_count_nxt;
  logic [fbfla_pkg::SIZE_W-1:0] block_size_r;
  logic [fbfla_pkg::SIZE_W-1:0] block_size_nxt;

  logic            push;
  fbfla_pkg::req_t push_req;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  fbfla_pkg::req_t q_req;
  fbfla_pkg::rsp_t rsp;

  always_comb begin
    block_count_nxt = block_count_r;
    block_size_nxt  = block_size_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        fbfla_pkg::CFG_BLOCK_COUNT: block_count_nxt = fbfla_pkg::CNT_W'(cfg_data);
        fbfla_pkg::CFG_BLOCK_SIZE:  block_size_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= fbfla_pkg::BLOCK_COUNT_RST;
      block_size_r  <= fbfla_pkg::BLOCK_SIZE_RST;
    end else begin
      block_count_r <= block_count_nxt;
      block_size_r  <= block_size_nxt;
    end
  end

  fbfla_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_block_index (in_block_index),
    .block_count    (block_count_r),
    .q_full         (q_full),
    .push           (push),
    .push_req       (push_req)
  );

  fbfla_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_req (q_req)
  );

  fbfla_back #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .block_count (block_count_r),
    .block_size  (block_size_r),
    .q_empty     (q_empty),
    .q_req       (q_req),
    .q_pop       (q_pop),
    .rsp_valid   (out_valid),
    .rsp         (rsp)
  );

  assign out_status           = rsp.status;
  assign out_granted_index    = rsp.gidx;
  assign out_granted_address  = rsp.gaddr;
  assign out_bytes_in_use     = rsp.used;
  assign out_live_allocations = rsp.live;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("request queue filled up");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result strobe missing after request transfer");

  a_no_grant_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != fbfla_pkg::ST_OK)
      |-> (out_granted_index == '0 && out_granted_address == '0))
    else $error("grant reported on a failed request");

endmodule

[design/fbfla_front.sv]
// ----------------------------------------------------------------------------
// fbfla_front
// request intake: takes a command and classifies it against the pool limit
// ----------------------------------------------------------------------------
module fbfla_front #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [fbfla_pkg::IDX_W-1:0]   in_block_index,
  input  logic [fbfla_pkg::CNT_W-1:0]   block_count,
  input  logic                          q_full,
  output logic                          push,
  output fbfla_pkg::req_t               push_req
);

  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = (LW > fbfla_pkg::CNT_W) ? LW : fbfla_pkg::CNT_W;

  logic [CW-1:0] bc_w;
  logic [CW-1:0] max_w;
  logic [CW-1:0] limit;

  always_comb begin
    bc_w  = CW'(block_count);
    max_w = CW'(MAX_BLOCKS);
    limit = (bc_w < max_w) ? bc_w : max_w;
  end

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_req.is_free   = (in_operation == fbfla_pkg::OP_FREE);
    push_req.range_bad = (CW'(in_block_index) >= limit);
    push_req.idx       = in_block_index;
  end

endmodule

[design/fbfla_queue.sv]
// ----------------------------------------------------------------------------
// fbfla_queue
// two-entry request queue between intake and execution
// ----------------------------------------------------------------------------
module fbfla_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fbfla_pkg::req_t push_req,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output fbfla_pkg::req_t head_req
);

  fbfla_pkg::req_t entry_r [2];
  logic            wr_ptr_r;
  logic            wr_ptr_nxt;
  logic            rd_ptr_r;
  logic            rd_ptr_nxt;
  logic [1:0]      count_r;
  logic [1:0]      count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign head_req = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

[design/fbfla_back.sv]
// ----------------------------------------------------------------------------
// fbfla_back
// execution: free list pops and pushes, fresh blocks, counters and result
// ----------------------------------------------------------------------------
module fbfla_back #(
  parameter int MAX_BLOCKS   = 1024,
  parameter int HEADER_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fbfla_pkg::CNT_W-1:0]   block_count,
  input  logic [fbfla_pkg::SIZE_W-1:0]  block_size,
  input  logic                          q_empty,
  input  fbfla_pkg::req_t               q_req,
  output logic                          q_pop,
  output logic                          rsp_valid,
  output fbfla_pkg::rsp_t               rsp
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = (LW > fbfla_pkg::CNT_W) ? LW : fbfla_pkg::CNT_W;
  localparam int AW = fbfla_pkg::ADDR_W;

  logic [IW-1:0] link_mem [MAX_BLOCKS];
  logic [IW-1:0] rdata_r;

  logic [IW-1:0] head_r;
  logic [IW-1:0] head_nxt;
  logic          pend_r;
  logic          pend_nxt;
  logic          rvalid_r;
  logic          rvalid_nxt;
  logic [LW-1:0] fresh_r;
  logic [LW-1:0] fresh_nxt;
  logic [LW-1:0] live_r;
  logic [LW-1:0] live_nxt;
  logic [AW-1:0] used_r;
  logic [AW-1:0] used_nxt;
  logic          out_valid_r;
  fbfla_pkg::rsp_t rsp_r;
  fbfla_pkg::rsp_t rsp_nxt;

  logic [CW-1:0] bc_w;
  logic [CW-1:0] max_w;
  logic [CW-1:0] limit;
  logic [IW-1:0] head_cur;
  logic [IW-1:0] idx_w;
  logic [IW-1:0] blk;
  logic          exec;
  logic          is_alloc;
  logic          can_fresh;
  logic          alloc_ok;
  logic          list_pop;
  logic          free_ok;
  logic [fbfla_pkg::SIZE_W:0] stride;
  logic [AW-1:0] prod;

  always_comb begin
    bc_w      = CW'(block_count);
    max_w     = CW'(MAX_BLOCKS);
    limit     = (bc_w < max_w) ? bc_w : max_w;
    head_cur  = pend_r ? rdata_r : head_r;
    idx_w     = IW'(q_req.idx);
    exec      = !q_empty;
    is_alloc  = !q_req.is_free;
    can_fresh = (CW'(fresh_r) < limit);
    alloc_ok  = exec && is_alloc && (rvalid_r || can_fresh);
    list_pop  = alloc_ok && rvalid_r;
    free_ok   = exec && q_req.is_free && !q_req.range_bad && (live_r != '0);
    blk       = rvalid_r ? head_cur : IW'(fresh_r);
    stride    = {1'b0, block_size} + (fbfla_pkg::SIZE_W + 1)'(HEADER_BYTES);
    prod      = AW'(blk) * AW'(stride);
  end

  assign q_pop = exec;

  always_comb begin
    fresh_nxt  = fresh_r;
    live_nxt   = live_r;
    used_nxt   = used_r;
    rvalid_nxt = rvalid_r;
    head_nxt   = head_cur;
    pend_nxt   = 1'b0;
    if (alloc_ok) begin
      if (!rvalid_r) begin
        fresh_nxt = fresh_r + LW'(1);
      end
      live_nxt   = live_r + LW'(1);
      used_nxt   = used_r + AW'(block_size);
      rvalid_nxt = (fresh_nxt > live_nxt);
      if (list_pop) begin
        head_nxt = head_r;
        pend_nxt = 1'b1;
      end
    end else if (free_ok) begin
      live_nxt   = live_r - LW'(1);
      used_nxt   = used_r - AW'(block_size);
      rvalid_nxt = 1'b1;
      head_nxt   = idx_w;
    end
  end

  always_comb begin
    rsp_nxt.status = fbfla_pkg::ST_OK;
    rsp_nxt.gidx   = '0;
    rsp_nxt.gaddr  = '0;
    if (is_alloc) begin
      if (alloc_ok) begin
        rsp_nxt.gidx  = fbfla_pkg::IDX_W'(blk);
        rsp_nxt.gaddr = prod + AW'(HEADER_BYTES);
      end else begin
        rsp_nxt.status = fbfla_pkg::ST_EMPTY;
      end
    end else if (!free_ok) begin
      rsp_nxt.status = fbfla_pkg::ST_REJECT;
    end
    rsp_nxt.used = used_nxt;
    rsp_nxt.live = fbfla_pkg::CNT_W'(live_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      pend_r      <= 1'b0;
      rvalid_r    <= 1'b0;
      fresh_r     <= '0;
      live_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      pend_r      <= pend_nxt;
      rvalid_r    <= rvalid_nxt;
      fresh_r     <= fresh_nxt;
      live_r      <= live_nxt;
      used_r      <= used_nxt;
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp_r <= rsp_nxt;
    end
  end

  // link store: push writes the old head, pop reads the next link
  always_ff @(posedge clk) begin
    if (free_ok) begin
      link_mem[idx_w] <= head_cur;
    end
    if (list_pop) begin
      rdata_r <= link_mem[head_cur];
    end
  end

  assign rsp_valid = out_valid_r;
  assign rsp       = rsp_r;

endmodule
